// ===== design/imhq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the heap queue.
package imhq_pkg;

	localparam int CAPACITY = 1024;
	localparam int PW       = $clog2(CAPACITY);
	localparam int CW       = PW + 1;
	localparam int HW       = 10;
	localparam int HANDLES  = 1 << HW;
	localparam int KW       = 32;

	typedef enum logic [1:0] {
		K_INSERT  = 2'd0,
		K_EXTRACT = 2'd1,
		K_DELETE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_INS_START,
		OP_ERR,
		OP_RD_ROOT,
		OP_RD_DEL,
		OP_TAKE_RES,
		OP_RD_PARENT,
		OP_UP_MOVE,
		OP_REMOVE,
		OP_LOAD_LAST,
		OP_RD_LEFT,
		OP_LEFT_CMP,
		OP_RIGHT_CMP,
		OP_DN_MOVE,
		OP_FINAL,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_UP,
		S_UPCMP,
		S_TAKE,
		S_DTAKE,
		S_DUP,
		S_DMOVE,
		S_REMOVE,
		S_LAST,
		S_DN,
		S_LCMP,
		S_RCMP,
		S_DEC,
		S_EMIT
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic present;
		logic pos_ok;
		logic cnt_zero;
		logic cnt_one;
		logic full;
		logic pos_zero;
		logic up_less;
		logic left_in;
		logic right_in;
		logic best_child;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

// ===== design/imhq_ctrl.sv =====
// Controller state machine that sequences every heap operation.
module imhq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  imhq_pkg::stat_t stat,
	output imhq_pkg::cmd_t  cmd
);
	import imhq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_EMIT;
				case (stat.kind)
					K_INSERT: begin
						if (stat.present) begin
							cmd.op = OP_ERR; cmd.code = ST_ABSENT;
						end else if (stat.full) begin
							cmd.op = OP_ERR; cmd.code = ST_FULL;
						end else begin
							cmd.op  = OP_INS_START;
							state_d = S_UP;
						end
					end
					K_EXTRACT: begin
						if (stat.cnt_zero) begin
							cmd.op = OP_ERR; cmd.code = ST_EMPTY;
						end else begin
							cmd.op  = OP_RD_ROOT;
							state_d = S_TAKE;
						end
					end
					K_DELETE: begin
						if (stat.cnt_zero) begin
							cmd.op = OP_ERR; cmd.code = ST_EMPTY;
						end else if (!stat.present || !stat.pos_ok) begin
							cmd.op = OP_ERR; cmd.code = ST_ABSENT;
						end else begin
							cmd.op  = OP_RD_DEL;
							state_d = S_DTAKE;
						end
					end
					default: begin
						cmd.op = OP_NONE;
					end
				endcase
			end
			S_UP: begin
				if (stat.pos_zero) begin
					cmd.op  = OP_FINAL;
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_RD_PARENT;
					state_d = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (stat.up_less) begin
					cmd.op  = OP_UP_MOVE;
					state_d = S_UP;
				end else begin
					cmd.op  = OP_FINAL;
					state_d = S_EMIT;
				end
			end
			S_TAKE: begin
				cmd.op  = OP_TAKE_RES;
				state_d = S_REMOVE;
			end
			S_DTAKE: begin
				cmd.op  = OP_TAKE_RES;
				state_d = S_DUP;
			end
			S_DUP: begin
				// A deleted entry climbs to the root unconditionally; ancestors shift down.
				if (stat.pos_zero) begin
					cmd.op  = OP_REMOVE;
					state_d = stat.cnt_one ? S_EMIT : S_LAST;
				end else begin
					cmd.op  = OP_RD_PARENT;
					state_d = S_DMOVE;
				end
			end
			S_DMOVE: begin
				cmd.op  = OP_UP_MOVE;
				state_d = S_DUP;
			end
			S_REMOVE: begin
				cmd.op  = OP_REMOVE;
				state_d = stat.cnt_one ? S_EMIT : S_LAST;
			end
			S_LAST: begin
				cmd.op  = OP_LOAD_LAST;
				state_d = S_DN;
			end
			S_DN: begin
				if (stat.left_in) begin
					cmd.op  = OP_RD_LEFT;
					state_d = S_LCMP;
				end else begin
					cmd.op  = OP_FINAL;
					state_d = S_EMIT;
				end
			end
			S_LCMP: begin
				cmd.op  = OP_LEFT_CMP;
				state_d = stat.right_in ? S_RCMP : S_DEC;
			end
			S_RCMP: begin
				cmd.op  = OP_RIGHT_CMP;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (stat.best_child) begin
					cmd.op  = OP_DN_MOVE;
					state_d = S_DN;
				end else begin
					cmd.op  = OP_FINAL;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/imhq_dp.sv =====
// Datapath: heap slot memory, handle table, work registers and output register.
module imhq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imhq_pkg::cmd_t                cmd,
	output imhq_pkg::stat_t               stat,
	input  logic [1:0]                    kind,
	input  logic [imhq_pkg::HW-1:0]       item_handle,
	input  logic signed [imhq_pkg::KW-1:0] item_key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [imhq_pkg::HW-1:0]       out_handle,
	output logic signed [imhq_pkg::KW-1:0] out_key,
	output logic [1:0]                    status,
	output logic [imhq_pkg::CW-1:0]       entries_after
);
	import imhq_pkg::*;

	// Heap slots and the handle table (present bit above the slot index).
	logic signed [KW-1:0] slot_key_mem [CAPACITY];
	logic [HW-1:0]        slot_hdl_mem [CAPACITY];
	logic [PW:0]          hm_mem [HANDLES];

	logic signed [KW-1:0] rd_key_q;
	logic [HW-1:0]        rd_hdl_q;
	logic [PW:0]          hm_rd_q;

	logic [HW-1:0]        clr_q;
	logic [1:0]           kind_q;
	logic [HW-1:0]        op_hdl_q;
	logic signed [KW-1:0] op_key_q;
	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        pos_q;
	logic signed [KW-1:0] mv_key_q, res_key_q, best_key_q;
	logic [HW-1:0]        mv_hdl_q, res_hdl_q, best_hdl_q;
	logic [PW-1:0]        best_pos_q;
	logic                 best_child_q;
	status_t              st_q;

	logic                 out_valid_q;
	logic [HW-1:0]        out_handle_q;
	logic signed [KW-1:0] out_key_q;
	status_t              out_status_q;
	logic [CW-1:0]        out_cnt_q;

	logic [PW-1:0] parent, rd_addr, wr_addr, last_idx;
	logic [CW-1:0] left_w, right_w;
	logic          slot_re, slot_we, hm_re, hm_we;
	logic signed [KW-1:0] wr_key;
	logic [HW-1:0] wr_hdl, hm_ra, hm_wa;
	logic [PW:0]   hm_wd;
	logic          out_free;

	assign parent   = (pos_q - PW'(1)) >> 1;
	assign left_w   = {pos_q, 1'b1};
	assign right_w  = left_w + CW'(1);
	assign last_idx = PW'(cnt_q - CW'(1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		slot_re = 1'b0; rd_addr = '0;
		slot_we = 1'b0; wr_addr = pos_q; wr_key = rd_key_q; wr_hdl = rd_hdl_q;
		hm_re   = 1'b0; hm_ra   = item_handle;
		hm_we   = 1'b0; hm_wa   = rd_hdl_q; hm_wd = {1'b1, pos_q};
		case (cmd.op)
			OP_CLEAR: begin
				hm_we = 1'b1; hm_wa = clr_q; hm_wd = '0;
			end
			OP_ACCEPT: begin
				hm_re = 1'b1;
			end
			OP_INS_START: begin
				hm_we = 1'b1; hm_wa = op_hdl_q; hm_wd = {1'b1, cnt_q[PW-1:0]};
			end
			OP_RD_ROOT: begin
				slot_re = 1'b1;
			end
			OP_RD_DEL: begin
				slot_re = 1'b1; rd_addr = hm_rd_q[PW-1:0];
			end
			OP_RD_PARENT: begin
				slot_re = 1'b1; rd_addr = parent;
			end
			OP_UP_MOVE: begin
				slot_we = 1'b1; hm_we = 1'b1;
			end
			OP_REMOVE: begin
				hm_we = 1'b1; hm_wa = res_hdl_q; hm_wd = '0;
				slot_re = 1'b1; rd_addr = last_idx;
			end
			OP_RD_LEFT: begin
				slot_re = 1'b1; rd_addr = left_w[PW-1:0];
			end
			OP_LEFT_CMP: begin
				slot_re = right_w < cnt_q; rd_addr = right_w[PW-1:0];
			end
			OP_DN_MOVE: begin
				slot_we = 1'b1; wr_key = best_key_q; wr_hdl = best_hdl_q;
				hm_we = 1'b1; hm_wa = best_hdl_q;
			end
			OP_FINAL: begin
				slot_we = 1'b1; wr_key = mv_key_q; wr_hdl = mv_hdl_q;
				hm_we = 1'b1; hm_wa = mv_hdl_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_key_mem[wr_addr] <= wr_key;
			slot_hdl_mem[wr_addr] <= wr_hdl;
		end
		if (slot_re) begin
			rd_key_q <= slot_key_mem[rd_addr];
			rd_hdl_q <= slot_hdl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hm_we) hm_mem[hm_wa] <= hm_wd;
		if (hm_re) hm_rd_q <= hm_mem[hm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + HW'(1);
			if (cmd.op == OP_INS_START) cnt_q <= cnt_q + CW'(1);
			if (cmd.op == OP_REMOVE) cnt_q <= cnt_q - CW'(1);
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				kind_q    <= kind;
				op_hdl_q  <= item_handle;
				op_key_q  <= item_key;
				res_key_q <= '0;
				res_hdl_q <= '0;
				st_q      <= ST_OK;
			end
			OP_ERR: begin
				st_q <= cmd.code;
			end
			OP_INS_START: begin
				pos_q    <= cnt_q[PW-1:0];
				mv_key_q <= op_key_q;
				mv_hdl_q <= op_hdl_q;
			end
			OP_RD_DEL: begin
				pos_q <= hm_rd_q[PW-1:0];
			end
			OP_TAKE_RES: begin
				res_key_q <= rd_key_q;
				res_hdl_q <= rd_hdl_q;
			end
			OP_UP_MOVE: begin
				pos_q <= parent;
			end
			OP_LOAD_LAST: begin
				mv_key_q <= rd_key_q;
				mv_hdl_q <= rd_hdl_q;
				pos_q    <= '0;
			end
			OP_LEFT_CMP: begin
				if (rd_key_q > mv_key_q) begin
					best_key_q   <= rd_key_q;
					best_hdl_q   <= rd_hdl_q;
					best_pos_q   <= left_w[PW-1:0];
					best_child_q <= 1'b1;
				end else begin
					best_key_q   <= mv_key_q;
					best_hdl_q   <= mv_hdl_q;
					best_pos_q   <= pos_q;
					best_child_q <= 1'b0;
				end
			end
			OP_RIGHT_CMP: begin
				if (rd_key_q > best_key_q) begin
					best_key_q   <= rd_key_q;
					best_hdl_q   <= rd_hdl_q;
					best_pos_q   <= right_w[PW-1:0];
					best_child_q <= 1'b1;
				end
			end
			OP_DN_MOVE: begin
				pos_q <= best_pos_q;
			end
			OP_EMIT: begin
				out_handle_q <= res_hdl_q;
				out_key_q    <= res_key_q;
				out_status_q <= st_q;
				out_cnt_q    <= cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.kind       = kind_q;
	assign stat.present    = hm_rd_q[PW];
	assign stat.pos_ok     = {1'b0, hm_rd_q[PW-1:0]} < cnt_q;
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.cnt_one    = (cnt_q == CW'(1));
	assign stat.full       = (cnt_q >= CW'(CAPACITY));
	assign stat.pos_zero   = (pos_q == '0);
	assign stat.up_less    = (rd_key_q < mv_key_q);
	assign stat.left_in    = (left_w < cnt_q);
	assign stat.right_in   = (right_w < cnt_q);
	assign stat.best_child = best_child_q;
	assign stat.clr_last   = &clr_q;
	assign stat.out_free   = out_free;

	assign out_valid     = out_valid_q;
	assign out_handle    = out_handle_q;
	assign out_key       = out_key_q;
	assign status        = out_status_q;
	assign entries_after = out_cnt_q;

endmodule

// ===== design/indexed_max_heap_queue.sv =====
// Indexed binary max-heap priority queue: insert, extract maximum and delete by handle.
// One operation is taken at a time; each returns exactly one result beat with a status
// and the entry count afterwards. Insert climbs from the new slot towards the root, extract
// descends from the root (one heap memory read port is shared by both children), and
// delete first moves the entry up to the root. A full heap holds 1024 entries, and a
// result beat waits while out_stall is high. After reset the whole handle table is swept
// clear, during which in_stall stays high. A waiting result beat does not block the next
// operation from being accepted.
module indexed_max_heap_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [imhq_pkg::HW-1:0]        item_handle,
	input  logic signed [imhq_pkg::KW-1:0] item_key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [imhq_pkg::HW-1:0]        out_handle,
	output logic signed [imhq_pkg::KW-1:0] out_key,
	output logic [1:0]                     status,
	output logic [imhq_pkg::CW-1:0]        entries_after
);
	import imhq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	imhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	imhq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.item_handle   (item_handle),
		.item_key      (item_key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_handle    (out_handle),
		.out_key       (out_key),
		.status        (status),
		.entries_after (entries_after)
	);

endmodule

// ===== design/imhq_checker.sv =====
// Port-level checker for the heap queue and its bind to the top level.
module imhq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [imhq_pkg::HW-1:0]        out_handle,
	input logic signed [imhq_pkg::KW-1:0] out_key,
	input logic [1:0]                     status,
	input logic [imhq_pkg::CW-1:0]        entries_after
);
	import imhq_pkg::*;

	// A stalled result beat stays and keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_handle))
		else $error("stalled result beat changed");

	// Error beats carry no entry.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_handle == '0 && out_key == '0)
		else $error("error beat carries an entry");

	// A full report means the heap really is at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entries_after == CW'(CAPACITY))
		else $error("full status below capacity");

	// The count never exceeds capacity.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_after <= CW'(CAPACITY))
		else $error("entry count above capacity");

endmodule

bind indexed_max_heap_queue imhq_checker u_imhq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_handle    (out_handle),
	.out_key       (out_key),
	.status        (status),
	.entries_after (entries_after)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the indexed max-heap priority queue.
`timescale 1ns / 100ps

module testbench;
	import imhq_pkg::*;

	typedef struct {
		logic [HW-1:0]        handle;
		logic signed [KW-1:0] key;
		status_t              code;
		logic [CW-1:0]        count;
	} heap_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind = 2'd0;
	logic [HW-1:0]         item_handle = '0;
	logic signed [KW-1:0]  item_key = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [HW-1:0]         out_handle;
	logic signed [KW-1:0]  out_key;
	logic [1:0]            status;
	logic [CW-1:0]         entries_after;

	// Predictor state.
	logic signed [KW-1:0]  heap_keys [CAPACITY];
	logic [HW-1:0]         heap_handles [CAPACITY];
	int unsigned           handle_slot [HANDLES];
	bit                    handle_live [HANDLES];
	int unsigned           heap_size = 0;

	heap_result_t          pending_results [$];
	int                    mismatches = 0;
	int unsigned           send_idle_pct = 0;
	int unsigned           stall_pct = 0;

	always #5 clk = ~clk;

	indexed_max_heap_queue dut (.*);

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void place(int unsigned pos, logic signed [KW-1:0] k,
			logic [HW-1:0] h);
		heap_keys[pos] = k;
		heap_handles[pos] = h;
		handle_slot[h] = pos;
	endfunction

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic signed [KW-1:0] k;
		logic [HW-1:0] h;
		k = heap_keys[a];
		h = heap_handles[a];
		place(a, heap_keys[b], heap_handles[b]);
		place(b, k, h);
	endfunction

	function automatic void remove_root(ref heap_result_t r);
		int unsigned pos, l, rt, best;
		pos = 0;
		r.handle = heap_handles[0];
		r.key = heap_keys[0];
		handle_live[heap_handles[0]] = 1'b0;
		heap_size--;
		if (heap_size > 0) begin
			place(0, heap_keys[heap_size], heap_handles[heap_size]);
			forever begin
				l = 2 * pos + 1;
				rt = 2 * pos + 2;
				best = pos;
				if (l < heap_size && heap_keys[l] > heap_keys[best]) best = l;
				if (rt < heap_size && heap_keys[rt] > heap_keys[best]) best = rt;
				if (best == pos) break;
				swap_entries(best, pos);
				pos = best;
			end
		end
	endfunction

	function automatic heap_result_t predict_heap_op(logic [1:0] k,
			logic [HW-1:0] h, logic signed [KW-1:0] key);
		heap_result_t r;
		int unsigned pos;
		r.handle = '0;
		r.key = '0;
		r.code = ST_OK;
		case (k)
			K_INSERT: begin
				if (handle_live[h]) r.code = ST_ABSENT;
				else if (heap_size >= CAPACITY) r.code = ST_FULL;
				else begin
					pos = heap_size;
					heap_size++;
					place(pos, key, h);
					handle_live[h] = 1'b1;
					while (pos > 0 && heap_keys[(pos - 1) / 2] < heap_keys[pos]) begin
						swap_entries((pos - 1) / 2, pos);
						pos = (pos - 1) / 2;
					end
				end
			end
			K_EXTRACT: begin
				if (heap_size == 0) r.code = ST_EMPTY;
				else remove_root(r);
			end
			K_DELETE: begin
				if (heap_size == 0) r.code = ST_EMPTY;
				else if (!handle_live[h] || handle_slot[h] >= heap_size) r.code = ST_ABSENT;
				else begin
					pos = handle_slot[h];
					while (pos > 0) begin
						swap_entries((pos - 1) / 2, pos);
						pos = (pos - 1) / 2;
					end
					remove_root(r);
				end
			end
			default: ;
		endcase
		r.count = heap_size[CW-1:0];
		return r;
	endfunction

	// The next beat follows the accepted one directly unless the sender idles first.
	task automatic send_op(input logic [1:0] k, input logic [HW-1:0] h,
			input logic signed [KW-1:0] key);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		item_handle <= h;
		item_key <= key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_heap_op(k, h, key));
	endtask

	// Receiver side: random stall, check each accepted beat.
	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) report_mismatch("unexpected result beat");
			else begin
				e = pending_results.pop_front();
				if (out_handle !== e.handle)
					report_mismatch($sformatf("handle %0d, want %0d", out_handle, e.handle));
				if (out_key !== e.key)
					report_mismatch($sformatf("key %0d, want %0d", out_key, e.key));
				if (status !== e.code)
					report_mismatch($sformatf("status %0d, want %0d", status, e.code));
				if (entries_after !== e.count)
					report_mismatch($sformatf("count %0d, want %0d", entries_after, e.count));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic signed [KW-1:0] rand_key();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return $signed($urandom_range(7)) - 3;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [HW-1:0] free_handle();
		logic [HW-1:0] h;
		h = HW'($urandom());
		while (handle_live[h]) h++;
		return h;
	endfunction

	function automatic logic [HW-1:0] live_handle();
		int unsigned p;
		p = $urandom_range(heap_size - 1);
		return heap_handles[p];
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_directed();
		send_op(K_EXTRACT, 10'd0, 0);
		send_op(K_DELETE, 10'd5, 0);
		send_op(K_INSERT, 10'd0, 32'sh8000_0000);
		send_op(K_INSERT, 10'd1023, 32'sh7FFF_FFFF);
		send_op(K_INSERT, 10'd1023, 32'sh0001_0000);
		send_op(K_INSERT, 10'd341, 32'sh7FFF_FFFF);
		send_op(K_INSERT, 10'd682, 32'sh0000_0000);
		send_op(K_INSERT, 10'd7, -32'sh0001_8000);
		send_op(K_DELETE, 10'd99, 0);
		send_op(K_DELETE, 10'd0, 0);
		send_op(2'd3, 10'd1023, 32'shFFFF_FFFF);
		send_op(K_EXTRACT, 10'd0, 0);
		send_op(K_DELETE, 10'd7, 0);
		send_op(K_EXTRACT, 10'd0, 0);
		send_op(K_EXTRACT, 10'd0, 0);
		send_op(K_EXTRACT, 10'd0, 0);
		wait_drained();
	endtask

	// Fill to capacity, where every handle is in use, then take entries off the full heap.
	task automatic test_full_heap();
		repeat (CAPACITY - heap_size) send_op(K_INSERT, free_handle(), rand_key());
		send_op(K_INSERT, 10'd0, 0);
		repeat (32) send_op(K_DELETE, live_handle(), 0);
		repeat (32) send_op(K_EXTRACT, 10'd0, 0);
		wait_drained();
	endtask

	task automatic test_random(input int unsigned items, input int unsigned idle,
			input int unsigned stall);
		int unsigned sel;
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (items) begin
			sel = $urandom_range(99);
			if (sel < 45 && heap_size < CAPACITY)
				send_op(K_INSERT, free_handle(), rand_key());
			else if (sel < 65) send_op(K_EXTRACT, HW'($urandom()), $urandom());
			else if (sel < 85 && heap_size > 0)
				send_op(K_DELETE, live_handle(), $urandom());
			else if (sel < 92)
				send_op(2'($urandom_range(3)), HW'($urandom()), $urandom());
			else send_op(K_DELETE, HW'($urandom()), $urandom());
		end
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(50, 0, 0);
		test_random(50, 54, 0);
		test_random(50, 0, 54);
		test_random(50, 13, 13);
		test_full_heap();
		if (mismatches == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/imhq_pkg.sv
design/imhq_ctrl.sv
design/imhq_dp.sv
design/indexed_max_heap_queue.sv
design/imhq_checker.sv
test/testbench.sv
